// ----- sv/pcm24_pk_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and register codes for the PCM24 encoder with peak buckets.
// No dependencies.
package pcm24_pk_pkg;

   localparam int SAMPLE_W = 26;   // input sample width, Q2.F
   localparam int PCM_W    = 24;
   localparam int PEAK_W   = 16;
   localparam int COUNT_W  = 16;   // bucket frame counter and period register
   localparam int CSR_W    = 16;   // widest configuration register

   // PCM scale is 2^23 - 1, peak scale is 2^15 - 1
   localparam int PCM_SHIFT  = PCM_W - 1;
   localparam int PEAK_SHIFT = PEAK_W - 1;

   typedef enum logic [0:0] {
      CSR_STEREO_MODE     = 1'b0,
      CSR_FRAMES_PER_PEAK = 1'b1
   } csr_index_type;

   // request operation codes
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [1:0] PCM_COUNT_NONE   = 2'd0;
   localparam logic [1:0] PCM_COUNT_MONO   = 2'd1;
   localparam logic [1:0] PCM_COUNT_STEREO = 2'd2;

   localparam logic [COUNT_W-1:0] FRAMES_PER_PEAK_RESET = 16'd256;

endpackage

// ----- sv/pcm24_pk_scale.sv -----
`timescale 1ns / 1ps
// Fixed-point scaler: multiply by (2^SHIFT - 1), round half to even at FRAC_BITS,
// saturate to +-(2^SHIFT - 1). Pure combinational, no package dependency.
module pcm24_pk_scale #(
   parameter int FRAC_BITS = 24,
   parameter int IN_W      = 26,
   parameter int SHIFT     = 23
) (
   input  logic signed [IN_W-1:0] value,
   output logic signed [SHIFT:0]  result
);

   localparam int PROD_W = IN_W + SHIFT + 1;
   localparam int QUO_W  = PROD_W - FRAC_BITS;
   localparam int RND_W  = QUO_W + 1;
   localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0] LIMIT_POS = RND_W'((2 ** SHIFT) - 1);
   localparam logic signed [RND_W-1:0] LIMIT_NEG = -LIMIT_POS;

   logic signed [PROD_W-1:0] value_ext;
   logic signed [PROD_W-1:0] product;
   logic signed [QUO_W-1:0]  quo_floor;
   logic        [FRAC_BITS-1:0] frac;
   logic                     round_up;
   logic signed [RND_W-1:0]  rounded;

   // x * (2^S - 1) as a shift and subtract
   assign value_ext = PROD_W'(value);
   assign product   = (value_ext <<< SHIFT) - value_ext;

   // floor quotient plus ties-to-even correction
   assign quo_floor = product[PROD_W-1:FRAC_BITS];
   assign frac      = product[FRAC_BITS-1:0];
   assign round_up  = (frac > HALF) || ((frac == HALF) && quo_floor[0]);
   assign rounded   = RND_W'(quo_floor) + RND_W'({1'b0, round_up});

   always_comb begin
      if (rounded > LIMIT_POS) begin
         result = LIMIT_POS[SHIFT:0];
      end else if (rounded < LIMIT_NEG) begin
         result = LIMIT_NEG[SHIFT:0];
      end else begin
         result = rounded[SHIFT:0];
      end
   end

endmodule

// ----- sv/pcm24_encoder_with_peak_buckets_core.sv -----
`timescale 1ns / 1ps
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req_op, req_left_sample, req_right_sample
//  rsp      out        rsp_valid/rsp_stall   rsp_pcm_count/left/right, rsp_peak_*
//  csr      in         csr_write             csr_index, csr_data
//
// One request per clock while req_stall is low; the accept edge loads the request
// register, and the response register behind the scaling multipliers loads from it
// once the response register is open (empty or not stalled).
// Bucket min/max/count update at the accept edge; scaling runs on the request register.
// Synchronous reset clears valids and bucket state and restores default configuration.
// A stalled response holds its register; the request register then fills and
// req_stall rises, so at most two requests are in flight.
// Depends on pcm24_pk_pkg and pcm24_pk_scale.
module pcm24_encoder_with_peak_buckets_core #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                       clock,
   input  logic                                       reset,

   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_op,
   input  logic signed [pcm24_pk_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  logic signed [pcm24_pk_pkg::SAMPLE_W-1:0]   req_right_sample,

   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic        [1:0]                          rsp_pcm_count,
   output logic signed [pcm24_pk_pkg::PCM_W-1:0]      rsp_pcm_left,
   output logic signed [pcm24_pk_pkg::PCM_W-1:0]      rsp_pcm_right,
   output logic                                       rsp_peak_valid,
   output logic signed [pcm24_pk_pkg::PEAK_W-1:0]     rsp_peak_low,
   output logic signed [pcm24_pk_pkg::PEAK_W-1:0]     rsp_peak_high,

   input  logic                                       csr_write,
   input  logic        [0:0]                          csr_index,
   input  logic        [pcm24_pk_pkg::CSR_W-1:0]      csr_data
);

   localparam int SW = pcm24_pk_pkg::SAMPLE_W;
   localparam int CW = pcm24_pk_pkg::COUNT_W;
   // bucket width must hold +-1.0 even when FRAC_BITS leaves no headroom
   localparam int BW = (FRAC_BITS + 2 > SW) ? FRAC_BITS + 2 : SW;
   localparam logic signed [BW-1:0] ONE_VAL     = BW'(2 ** FRAC_BITS);
   localparam logic signed [BW-1:0] NEG_ONE_VAL = -ONE_VAL;

   // configuration
   logic          stereo_mode_ff;
   logic [CW-1:0] frames_per_peak_ff;

   // bucket state
   logic signed [BW-1:0] bucket_min_ff, bucket_min_in;
   logic signed [BW-1:0] bucket_max_ff, bucket_max_in;
   logic        [CW-1:0] bucket_count_ff, bucket_count_in;

   // request register
   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_count_ff, s1_count_in;
   logic signed [BW-1:0] s1_left_ff, s1_left_in;
   logic signed [BW-1:0] s1_right_ff, s1_right_in;
   logic                 s1_peak_ff, s1_peak_in;
   logic signed [BW-1:0] s1_low_ff, s1_low_in;
   logic signed [BW-1:0] s1_high_ff, s1_high_in;

   // response register
   logic                                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                                rsp_count_ff;
   logic signed [pcm24_pk_pkg::PCM_W-1:0]     rsp_left_ff, rsp_left_in;
   logic signed [pcm24_pk_pkg::PCM_W-1:0]     rsp_right_ff, rsp_right_in;
   logic                                      rsp_peak_ff;
   logic signed [pcm24_pk_pkg::PEAK_W-1:0]    rsp_low_ff, rsp_low_in;
   logic signed [pcm24_pk_pkg::PEAK_W-1:0]    rsp_high_ff, rsp_high_in;

   logic out_open, s1_adv, s1_open, req_take;
   logic signed [BW-1:0] left_ext, right_ext, lo_val, hi_val;
   logic signed [BW-1:0] min_upd, max_upd;
   logic [CW-1:0] count_upd;
   logic bucket_full;

   // handshake
   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_open;
   assign s1_open   = !s1_valid_ff || out_open;
   assign req_stall = !s1_open;
   assign req_take  = req_valid && s1_open;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = out_open ? s1_valid_ff : rsp_valid_ff;

   function automatic logic signed [BW-1:0] clamp_unit(input logic signed [BW-1:0] x);
      logic signed [BW-1:0] y;
      if (x > ONE_VAL) begin
         y = ONE_VAL;
      end else if (x < NEG_ONE_VAL) begin
         y = NEG_ONE_VAL;
      end else begin
         y = x;
      end
      return y;
   endfunction

   // frame min/max; mono uses left for both
   assign left_ext  = BW'(req_left_sample);
   assign right_ext = stereo_mode_ff ? BW'(req_right_sample) : left_ext;
   assign lo_val    = (left_ext < right_ext) ? left_ext : right_ext;
   assign hi_val    = (left_ext > right_ext) ? left_ext : right_ext;
   assign min_upd   = (lo_val < bucket_min_ff) ? lo_val : bucket_min_ff;
   assign max_upd   = (hi_val > bucket_max_ff) ? hi_val : bucket_max_ff;
   assign count_upd = bucket_count_ff + CW'(1);
   assign bucket_full = (count_upd >= frames_per_peak_ff);

   always_comb begin
      bucket_min_in   = bucket_min_ff;
      bucket_max_in   = bucket_max_ff;
      bucket_count_in = bucket_count_ff;
      s1_count_in     = pcm24_pk_pkg::PCM_COUNT_NONE;
      s1_left_in      = '0;
      s1_right_in     = '0;
      s1_peak_in      = 1'b0;
      s1_low_in       = '0;
      s1_high_in      = '0;
      if (req_op == pcm24_pk_pkg::OP_FLUSH) begin
         // flush: emit only a non-empty bucket
         if (bucket_count_ff != '0) begin
            s1_peak_in      = 1'b1;
            s1_low_in       = bucket_min_ff;
            s1_high_in      = bucket_max_ff;
            bucket_min_in   = ONE_VAL;
            bucket_max_in   = NEG_ONE_VAL;
            bucket_count_in = '0;
         end
      end else begin
         s1_count_in = stereo_mode_ff ? pcm24_pk_pkg::PCM_COUNT_STEREO
                                      : pcm24_pk_pkg::PCM_COUNT_MONO;
         s1_left_in  = clamp_unit(left_ext);
         s1_right_in = stereo_mode_ff ? clamp_unit(right_ext) : '0;
         if (bucket_full) begin
            s1_peak_in      = 1'b1;
            s1_low_in       = min_upd;
            s1_high_in      = max_upd;
            bucket_min_in   = ONE_VAL;
            bucket_max_in   = NEG_ONE_VAL;
            bucket_count_in = '0;
         end else begin
            bucket_min_in   = min_upd;
            bucket_max_in   = max_upd;
            bucket_count_in = count_upd;
         end
      end
   end

   pcm24_pk_scale #(.FRAC_BITS(FRAC_BITS), .IN_W(BW), .SHIFT(pcm24_pk_pkg::PCM_SHIFT))
      u_scale_left (.value(s1_left_ff), .result(rsp_left_in));
   pcm24_pk_scale #(.FRAC_BITS(FRAC_BITS), .IN_W(BW), .SHIFT(pcm24_pk_pkg::PCM_SHIFT))
      u_scale_right (.value(s1_right_ff), .result(rsp_right_in));
   pcm24_pk_scale #(.FRAC_BITS(FRAC_BITS), .IN_W(BW), .SHIFT(pcm24_pk_pkg::PEAK_SHIFT))
      u_scale_low (.value(s1_low_ff), .result(rsp_low_in));
   pcm24_pk_scale #(.FRAC_BITS(FRAC_BITS), .IN_W(BW), .SHIFT(pcm24_pk_pkg::PEAK_SHIFT))
      u_scale_high (.value(s1_high_ff), .result(rsp_high_in));

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mode_ff     <= 1'b1;
         frames_per_peak_ff <= pcm24_pk_pkg::FRAMES_PER_PEAK_RESET;
         bucket_min_ff      <= ONE_VAL;
         bucket_max_ff      <= NEG_ONE_VAL;
         bucket_count_ff    <= '0;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               pcm24_pk_pkg::CSR_STEREO_MODE:     stereo_mode_ff     <= csr_data[0];
               pcm24_pk_pkg::CSR_FRAMES_PER_PEAK: frames_per_peak_ff <= csr_data[CW-1:0];
               default: ;
            endcase
         end
         if (req_take) begin
            bucket_min_ff   <= bucket_min_in;
            bucket_max_ff   <= bucket_max_in;
            bucket_count_ff <= bucket_count_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_count_ff <= s1_count_in;
         s1_left_ff  <= s1_left_in;
         s1_right_ff <= s1_right_in;
         s1_peak_ff  <= s1_peak_in;
         s1_low_ff   <= s1_low_in;
         s1_high_ff  <= s1_high_in;
      end
      if (s1_adv) begin
         rsp_count_ff <= s1_count_ff;
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
         rsp_peak_ff  <= s1_peak_ff;
         rsp_low_ff   <= rsp_low_in;
         rsp_high_ff  <= rsp_high_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_count  = rsp_count_ff;
   assign rsp_pcm_left   = rsp_left_ff;
   assign rsp_pcm_right  = rsp_right_ff;
   assign rsp_peak_valid = rsp_peak_ff;
   assign rsp_peak_low   = rsp_low_ff;
   assign rsp_peak_high  = rsp_high_ff;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pcm24_encoder_with_peak_buckets_core: random and directed frames.
// A small scoreboard predicts the PCM words and peak buckets of each request.
// Depends on pcm24_pk_pkg and the core RTL.
module tb;

   localparam int     SAMPLE_W       = pcm24_pk_pkg::SAMPLE_W;
   localparam int     PCM_W          = pcm24_pk_pkg::PCM_W;
   localparam int     PEAK_W         = pcm24_pk_pkg::PEAK_W;
   localparam int     COUNT_W        = pcm24_pk_pkg::COUNT_W;
   localparam int     CSR_W          = pcm24_pk_pkg::CSR_W;
   localparam int     FRAC           = 24;
   localparam longint ONE_Q          = 64'sd1 <<< FRAC;
   localparam longint PCM_SCALE      = (64'sd1 <<< pcm24_pk_pkg::PCM_SHIFT) - 1;
   localparam longint PEAK_SCALE     = (64'sd1 <<< pcm24_pk_pkg::PEAK_SHIFT) - 1;
   localparam int     WATCHDOG_LIMIT = 2000;
   localparam int     LONG_HOLD      = 300;

   typedef struct {
      logic [1:0]              pcm_count;
      logic signed [PCM_W-1:0] pcm_left;
      logic signed [PCM_W-1:0] pcm_right;
      logic                    peak_valid;
      logic signed [PEAK_W-1:0] peak_low;
      logic signed [PEAK_W-1:0] peak_high;
   } pcm_peak_type;

   class pcm_bucket_board_type;
      pcm_peak_type        expected_q[$];
      bit                  stereo;
      logic [COUNT_W-1:0]  period;
      logic [COUNT_W-1:0]  bucket_frames;
      longint              bucket_lo;
      longint              bucket_hi;
      int                  errors;
      int                  served;

      function new();
         stereo = 1'b1;
         period = pcm24_pk_pkg::FRAMES_PER_PEAK_RESET;
         errors = 0;
         served = 0;
         clear_bucket();
      endfunction

      function void clear_bucket();
         bucket_lo     = ONE_Q;
         bucket_hi     = -ONE_Q;
         bucket_frames = '0;
      endfunction

      // v / 2^FRAC, nearest, ties to even
      function longint round_half_even(longint v);
         bit                neg;
         longint unsigned   mag, q, rem, half;
         neg  = v < 0;
         mag  = neg ? -v : v;
         q    = mag >> FRAC;
         rem  = mag & ((64'd1 << FRAC) - 1);
         half = 64'd1 << (FRAC - 1);
         if (rem > half || (rem == half && q[0])) begin
            q++;
         end
         return neg ? -longint'(q) : longint'(q);
      endfunction

      function longint pcm_of(longint x);
         if (x > ONE_Q) x = ONE_Q;
         if (x < -ONE_Q) x = -ONE_Q;
         return round_half_even(x * PCM_SCALE);
      endfunction

      function longint peak_of(longint x);
         longint r;
         r = round_half_even(x * PEAK_SCALE);
         if (r > PEAK_SCALE) r = PEAK_SCALE;
         if (r < -PEAK_SCALE) r = -PEAK_SCALE;
         return r;
      endfunction

      function void set_register(pcm24_pk_pkg::csr_index_type idx, logic [CSR_W-1:0] value);
         if (idx == pcm24_pk_pkg::CSR_STEREO_MODE) begin
            stereo = value[0];
         end else begin
            period = value;
         end
      endfunction

      function void emit_bucket(inout pcm_peak_type r);
         r.peak_valid = 1'b1;
         r.peak_low   = PEAK_W'(peak_of(bucket_lo));
         r.peak_high  = PEAK_W'(peak_of(bucket_hi));
         clear_bucket();
      endfunction

      function void note_request(logic op, logic signed [SAMPLE_W-1:0] left,
                                 logic signed [SAMPLE_W-1:0] right);
         pcm_peak_type r;
         longint       l, rr, lo, hi;
         r = '{default: '0};
         if (op == pcm24_pk_pkg::OP_FLUSH) begin
            if (bucket_frames != 0) emit_bucket(r);
         end else begin
            l  = left;
            rr = stereo ? longint'(right) : l;
            lo = (l < rr) ? l : rr;
            hi = (l > rr) ? l : rr;
            r.pcm_count = stereo ? pcm24_pk_pkg::PCM_COUNT_STEREO
                                 : pcm24_pk_pkg::PCM_COUNT_MONO;
            r.pcm_left  = PCM_W'(pcm_of(l));
            r.pcm_right = stereo ? PCM_W'(pcm_of(rr)) : '0;
            if (lo < bucket_lo) bucket_lo = lo;
            if (hi > bucket_hi) bucket_hi = hi;
            bucket_frames = bucket_frames + 1'b1;
            if (bucket_frames >= period) emit_bucket(r);
         end
         expected_q.insert(expected_q.size(), r);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task compare_field(string name, logic signed [31:0] got, logic signed [31:0] want);
         if (got !== want) begin
            report($sformatf("response %0d %s: got %0d, want %0d", served, name, got, want));
         end
      endtask

      task check_response(pcm_peak_type got);
         pcm_peak_type want;
         if (expected_q.size() == 0) begin
            report("response with no request waiting");
            return;
         end
         want = expected_q.pop_front();
         compare_field("pcm_count", got.pcm_count, want.pcm_count);
         compare_field("pcm_left", got.pcm_left, want.pcm_left);
         compare_field("pcm_right", got.pcm_right, want.pcm_right);
         compare_field("peak_valid", got.peak_valid, want.peak_valid);
         compare_field("peak_low", got.peak_low, want.peak_low);
         compare_field("peak_high", got.peak_high, want.peak_high);
         served++;
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = pcm24_pk_pkg::OP_FRAME;
   logic signed [SAMPLE_W-1:0]  req_left_sample = '0;
   logic signed [SAMPLE_W-1:0]  req_right_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [1:0]                  rsp_pcm_count;
   logic signed [PCM_W-1:0]     rsp_pcm_left;
   logic signed [PCM_W-1:0]     rsp_pcm_right;
   logic                        rsp_peak_valid;
   logic signed [PEAK_W-1:0]    rsp_peak_low;
   logic signed [PEAK_W-1:0]    rsp_peak_high;
   logic                        csr_write = 1'b0;
   logic [0:0]                  csr_index = pcm24_pk_pkg::CSR_STEREO_MODE;
   logic [CSR_W-1:0]            csr_data = '0;

   pcm_bucket_board_type sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   pcm24_encoder_with_peak_buckets_core #(.FRAC_BITS(FRAC)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pcm_count    (rsp_pcm_count),
      .rsp_pcm_left     (rsp_pcm_left),
      .rsp_pcm_right    (rsp_pcm_right),
      .rsp_peak_valid   (rsp_peak_valid),
      .rsp_peak_low     (rsp_peak_low),
      .rsp_peak_high    (rsp_peak_high),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long hold whenever a new ticket shows up
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen <= hold_ticket;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Track accepted requests and responses; end the run if traffic stops
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_op, req_left_sample, req_right_sample);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(pcm_peak_type'{rsp_pcm_count, rsp_pcm_left, rsp_pcm_right,
                                             rsp_peak_valid, rsp_peak_low, rsp_peak_high});
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_frame(input logic op, input logic signed [SAMPLE_W-1:0] left,
                             input logic signed [SAMPLE_W-1:0] right);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_left_sample  <= left;
      req_right_sample <= right;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every response is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input pcm24_pk_pkg::csr_index_type idx,
                                 input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_register(idx, value[CSR_W-1:0]);
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      int                         mag;
      case ($urandom_range(9))
         0, 1, 2: s = SAMPLE_W'($urandom);
         3: begin
            case ($urandom_range(6))
               0: s = 26'sd16777216;
               1: s = -26'sd16777216;
               2: s = 26'sd8388608;
               3: s = -26'sd8388608;
               4: s = 26'sd33554431;
               5: s = -26'sd33554432;
               default: s = '0;
            endcase
         end
         4, 5: begin
            mag = int'(ONE_Q) + int'($urandom_range(4096)) - 2048;
            s   = $urandom_range(1) ? SAMPLE_W'(mag) : SAMPLE_W'(-mag);
         end
         default: s = SAMPLE_W'(int'($urandom_range(2 * int'(ONE_Q))) - int'(ONE_Q));
      endcase
      return s;
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: stereo, 256 frames per bucket
      send_frame(pcm24_pk_pkg::OP_FLUSH, 26'sd0, 26'sd0);   // flush with empty bucket
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd0, 26'sd0);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd33554431, -26'sd33554432);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd16777216, -26'sd16777216);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd8388608, -26'sd8388608);   // rounding ties
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd1, -26'sd1);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd16777215, -26'sd16777215);
      send_frame(pcm24_pk_pkg::OP_FLUSH, 26'sd0, 26'sd0);   // partial bucket, saturated peaks
      send_frame(pcm24_pk_pkg::OP_FLUSH, -26'sd1, 26'sd33554431);
      settle();

      // Mono, one frame per bucket: right channel ignored
      write_register(pcm24_pk_pkg::CSR_STEREO_MODE, 0);
      write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 1);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd8388608, 26'sd33554431);
      send_frame(pcm24_pk_pkg::OP_FRAME, -26'sd33554432, 26'sd5);
      settle();

      // Zero frames per peak acts as one
      write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 0);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd12345, 26'sd0);
      send_frame(pcm24_pk_pkg::OP_FLUSH, 26'sd0, 26'sd0);
      settle();

      // Lower the period while a bucket is partly full
      write_register(pcm24_pk_pkg::CSR_STEREO_MODE, 1);
      write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 6);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd100, -26'sd200);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd3000000, 26'sd5);
      send_frame(pcm24_pk_pkg::OP_FRAME, -26'sd7000000, 26'sd0);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd1, 26'sd2);
      settle();
      write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 2);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd4, 26'sd4);
      send_frame(pcm24_pk_pkg::OP_FLUSH, 26'sd0, 26'sd0);
      settle();

      write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 65535);
      send_frame(pcm24_pk_pkg::OP_FRAME, 26'sd20000000, -26'sd3);
      send_frame(pcm24_pk_pkg::OP_FRAME, -26'sd9, 26'sd7);
      send_frame(pcm24_pk_pkg::OP_FLUSH, 26'sd0, 26'sd0);

      for (int k = 0; k < 8; k++) begin
         settle();
         case (k)
            0: begin
               write_register(pcm24_pk_pkg::CSR_STEREO_MODE, 0);
               write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 1);
            end
            1: begin
               write_register(pcm24_pk_pkg::CSR_STEREO_MODE, 1);
               write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 65535);
            end
            2: write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 4);
            3: begin
               write_register(pcm24_pk_pkg::CSR_STEREO_MODE, 0);
               write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK, 0);
            end
            default: begin
               write_register(pcm24_pk_pkg::CSR_STEREO_MODE, $urandom_range(1));
               write_register(pcm24_pk_pkg::CSR_FRAMES_PER_PEAK,
                              ($urandom_range(3) == 0) ?
                              $urandom_range(300, 1) : $urandom_range(24, 1));
            end
         endcase
         case (k % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         // hold the receiver off while the sender keeps pushing
         if (k == 2) hold_ticket <= hold_ticket + 1;
         for (int n = 0; n < 190; n++) begin
            send_frame(($urandom_range(15) == 0) ? pcm24_pk_pkg::OP_FLUSH
                                                 : pcm24_pk_pkg::OP_FRAME,
                       pick_sample(), pick_sample());
         end
      end

      settle();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
